// ===== rtl/bsm_pkg.sv =====
// bsm_pkg: shared types and constants for the bank switch mapper
// holds event/config structs, write decode codes and counter constants
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package bsm_pkg;

    // input operation codes
    typedef enum logic [1:0] {
        OP_REG_WRITE  = 2'd0,
        OP_PRG_XLATE  = 2'd1,
        OP_CHR_ACCESS = 2'd2,
        OP_CPU_TICK   = 2'd3
    } t_op;

    // decoded mapper register write
    typedef enum logic [2:0] {
        WR_NONE      = 3'd0,
        WR_BANK_SEL  = 3'd1,
        WR_BANK_DATA = 3'd2,
        WR_MIRROR    = 3'd3,
        WR_RELOAD    = 3'd4,
        WR_IRQ_RESET = 3'd5,
        WR_IRQ_DIS   = 3'd6,
        WR_IRQ_EN    = 3'd7
    } t_wsel;

    // configuration register indexes
    typedef enum logic {
        CFG_PRG_MASK = 1'b0,
        CFG_CHR_MASK = 1'b1
    } t_cfg_idx;

    localparam int PRG_W   = 21;
    localparam int CHR_W   = 18;
    localparam int CFG_W   = 21;

    localparam logic [15:0] WR_DECODE_MASK  = 16'hE001;
    localparam logic [15:0] ADDR_BANK_SEL   = 16'h8000;
    localparam logic [15:0] ADDR_BANK_DATA  = 16'h8001;
    localparam logic [15:0] ADDR_MIRROR     = 16'hA000;
    localparam logic [15:0] ADDR_RELOAD     = 16'hC000;
    localparam logic [15:0] ADDR_IRQ_RESET  = 16'hC001;
    localparam logic [15:0] ADDR_IRQ_DIS    = 16'hE000;
    localparam logic [15:0] ADDR_IRQ_EN     = 16'hE001;

    // bank data register index targets
    localparam logic [3:0] IDX_CHR0 = 4'd0;
    localparam logic [3:0] IDX_CHR2 = 4'd1;
    localparam logic [3:0] IDX_CHR4 = 4'd2;
    localparam logic [3:0] IDX_CHR5 = 4'd3;
    localparam logic [3:0] IDX_CHR6 = 4'd4;
    localparam logic [3:0] IDX_CHR7 = 4'd5;
    localparam logic [3:0] IDX_PRG0 = 4'd6;
    localparam logic [3:0] IDX_PRG1 = 4'd7;
    localparam logic [3:0] IDX_CHR1 = 4'd8;
    localparam logic [3:0] IDX_CHR3 = 4'd9;
    localparam logic [3:0] IDX_PRG2 = 4'd15;

    localparam logic [2:0] PRESCALE_DIV     = 3'd4;
    localparam logic [2:0] IRQ_DELAY_CYCLES = 3'd6;

    localparam logic [PRG_W-1:0] PRG_MASK_RST = 21'd131071;
    localparam logic [CHR_W-1:0] CHR_MASK_RST = 18'd8191;
    localparam logic [7:0]       RELOAD_RST   = 8'd255;

    // one event as seen by the state units
    typedef struct packed {
        logic        valid;
        t_wsel       wsel;
        logic        prg;
        logic        chr;
        logic        tick;
        logic [15:0] addr;
        logic [7:0]  data;
    } t_evt;

    typedef struct packed {
        logic             we;
        t_cfg_idx         index;
        logic [CFG_W-1:0] data;
    } t_cfg;

endpackage

`default_nettype wire

// ===== rtl/bsm_banks.sv =====
// bsm_banks: bank registers, mirroring, config masks and address translation
// depends on bsm_pkg
`timescale 1ns / 1ps
`default_nettype none

module bsm_banks (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire bsm_pkg::t_evt             i_evt,
    input  wire bsm_pkg::t_cfg             i_cfg,
    output logic [bsm_pkg::PRG_W-1:0]      o_mapped,
    output logic                           o_mirror
);

    logic [bsm_pkg::PRG_W-1:0] r_prg_mask;
    logic [bsm_pkg::CHR_W-1:0] r_chr_mask;
    logic [3:0]                r_reg_index, n_reg_index;
    logic                      r_chr_invert, n_chr_invert;
    logic                      r_chr_full, n_chr_full;
    logic                      r_prg_swap, n_prg_swap;
    logic                      r_mirror, n_mirror;
    logic [7:0]                r_chr_bank [8];
    logic [7:0]                n_chr_bank [8];
    logic [7:0]                r_prg_bank [3];
    logic [7:0]                n_prg_bank [3];

    logic [1:0]                prg_win;
    logic [1:0]                prg_sel;
    logic [bsm_pkg::PRG_W-1:0] prg_base;
    logic [bsm_pkg::PRG_W-1:0] prg_addr;
    logic [2:0]                chr_win;
    logic [7:0]                chr_pair;
    logic [7:0]                chr_bank;
    logic [bsm_pkg::CHR_W-1:0] chr_base;
    logic [bsm_pkg::CHR_W:0]   chr_sum;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prg_mask <= bsm_pkg::PRG_MASK_RST;
            r_chr_mask <= bsm_pkg::CHR_MASK_RST;
        end else if (i_cfg.we) begin
            unique case (i_cfg.index)
                bsm_pkg::CFG_PRG_MASK: r_prg_mask <= i_cfg.data;
                bsm_pkg::CFG_CHR_MASK: r_chr_mask <= i_cfg.data[bsm_pkg::CHR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_reg_index  = r_reg_index;
        n_chr_invert = r_chr_invert;
        n_chr_full   = r_chr_full;
        n_prg_swap   = r_prg_swap;
        n_mirror     = r_mirror;
        n_chr_bank   = r_chr_bank;
        n_prg_bank   = r_prg_bank;
        case (i_evt.wsel)
            bsm_pkg::WR_BANK_SEL: begin
                n_chr_invert = i_evt.data[7];
                n_prg_swap   = i_evt.data[6];
                n_chr_full   = i_evt.data[5];
                n_reg_index  = i_evt.data[3:0];
            end
            bsm_pkg::WR_BANK_DATA: begin
                unique case (r_reg_index)
                    bsm_pkg::IDX_CHR0: n_chr_bank[0] = i_evt.data;
                    bsm_pkg::IDX_CHR2: n_chr_bank[2] = i_evt.data;
                    bsm_pkg::IDX_CHR4: n_chr_bank[4] = i_evt.data;
                    bsm_pkg::IDX_CHR5: n_chr_bank[5] = i_evt.data;
                    bsm_pkg::IDX_CHR6: n_chr_bank[6] = i_evt.data;
                    bsm_pkg::IDX_CHR7: n_chr_bank[7] = i_evt.data;
                    bsm_pkg::IDX_PRG0: n_prg_bank[0] = i_evt.data;
                    bsm_pkg::IDX_PRG1: n_prg_bank[1] = i_evt.data;
                    bsm_pkg::IDX_CHR1: n_chr_bank[1] = i_evt.data;
                    bsm_pkg::IDX_CHR3: n_chr_bank[3] = i_evt.data;
                    bsm_pkg::IDX_PRG2: n_prg_bank[2] = i_evt.data;
                    default: ;
                endcase
            end
            bsm_pkg::WR_MIRROR: n_mirror = i_evt.data[0];
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reg_index  <= '0;
            r_chr_invert <= 1'b0;
            r_chr_full   <= 1'b0;
            r_prg_swap   <= 1'b0;
            r_mirror     <= 1'b0;
            for (int i = 0; i < 8; i++) begin
                r_chr_bank[i] <= '0;
            end
            for (int i = 0; i < 3; i++) begin
                r_prg_bank[i] <= 8'(i);
            end
        end else if (i_evt.valid) begin
            r_reg_index  <= n_reg_index;
            r_chr_invert <= n_chr_invert;
            r_chr_full   <= n_chr_full;
            r_prg_swap   <= n_prg_swap;
            r_mirror     <= n_mirror;
            r_chr_bank   <= n_chr_bank;
            r_prg_bank   <= n_prg_bank;
        end
    end

    // program window translate, last window fixed at top bank
    always_comb begin
        prg_win = i_evt.addr[14:13];
        if (r_prg_swap) begin
            prg_sel = (prg_win == 2'd0) ? 2'd2 : prg_win - 2'd1;
        end else begin
            prg_sel = prg_win;
        end
        if (prg_win == 2'd3) begin
            prg_base = {r_prg_mask[bsm_pkg::PRG_W-1:13], 13'd0};
        end else begin
            prg_base = {r_prg_bank[prg_sel], 13'd0};
        end
        prg_addr = (prg_base | {8'd0, i_evt.addr[12:0]}) & r_prg_mask;
    end

    // pattern window translate, 2 KB pairs force the low bank bit
    always_comb begin
        chr_win  = i_evt.addr[12:10] ^ {r_chr_invert, 2'b00};
        chr_pair = r_chr_bank[{1'b0, chr_win[1], 1'b0}];
        if (r_chr_full || chr_win[2]) begin
            chr_bank = r_chr_bank[chr_win];
        end else begin
            chr_bank = {chr_pair[7:1], chr_win[0]};
        end
        chr_base = {chr_bank, 10'd0} & r_chr_mask;
        chr_sum  = {1'b0, chr_base} + {9'd0, i_evt.addr[9:0]};
    end

    always_comb begin
        o_mapped = '0;
        if (i_evt.prg && i_evt.addr[15]) begin
            o_mapped = prg_addr;
        end else if (i_evt.chr && (i_evt.addr[15:13] == 3'd0)) begin
            o_mapped = {2'd0, chr_sum};
        end
    end

    assign o_mirror = n_mirror;

endmodule

`default_nettype wire

// ===== rtl/bsm_irq.sv =====
// bsm_irq: interrupt counter, a12 edge detect, cycle prescaler and irq delay
// depends on bsm_pkg
`timescale 1ns / 1ps
`default_nettype none

module bsm_irq (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire bsm_pkg::t_evt i_evt,
    output logic               o_irq
);

    logic [7:0] r_counter, n_counter;
    logic [7:0] r_reload, n_reload;
    logic       r_reload_req, n_reload_req;
    logic       r_enabled, n_enabled;
    logic       r_cycle_mode, n_cycle_mode;
    logic [2:0] r_prescaler, n_prescaler;
    logic [2:0] r_delay, n_delay;
    logic       r_prev_a12, n_prev_a12;
    logic       r_flag, n_flag;
    logic       counter_clk;
    logic       expired;

    always_comb begin
        n_counter    = r_counter;
        n_reload     = r_reload;
        n_reload_req = r_reload_req;
        n_enabled    = r_enabled;
        n_cycle_mode = r_cycle_mode;
        n_prescaler  = r_prescaler;
        n_delay      = r_delay;
        n_prev_a12   = r_prev_a12;
        n_flag       = r_flag;
        counter_clk  = 1'b0;
        expired      = 1'b0;

        case (i_evt.wsel)
            bsm_pkg::WR_RELOAD: n_reload = i_evt.data;
            bsm_pkg::WR_IRQ_RESET: begin
                n_reload_req = 1'b1;
                n_prescaler  = bsm_pkg::PRESCALE_DIV;
                n_cycle_mode = i_evt.data[0];
            end
            bsm_pkg::WR_IRQ_DIS, bsm_pkg::WR_IRQ_EN: begin
                n_enabled = (i_evt.wsel == bsm_pkg::WR_IRQ_EN);
                n_delay   = '0;
                n_flag    = 1'b0;
            end
            default: ;
        endcase

        // rising a12 on a pattern fetch
        if (i_evt.chr && (i_evt.addr[15:13] == 3'd0)) begin
            counter_clk = i_evt.addr[12] && !r_prev_a12 && !r_cycle_mode;
            n_prev_a12  = i_evt.addr[12];
        end

        if (i_evt.tick) begin
            if (r_delay != 3'd0) begin
                n_delay = r_delay - 3'd1;
                if (n_delay == 3'd0) begin
                    n_flag  = 1'b1;
                    expired = 1'b1;
                end
            end
            if (!expired && r_cycle_mode) begin
                n_prescaler = r_prescaler - 3'd1;
                if (n_prescaler == 3'd0) begin
                    n_prescaler = bsm_pkg::PRESCALE_DIV;
                    counter_clk = 1'b1;
                end
            end
        end

        if (counter_clk) begin
            if (r_reload_req) begin
                n_reload_req = 1'b0;
                n_counter    = r_reload | {7'd0, (r_reload != 8'd0)};
            end else if (r_counter == 8'd0) begin
                n_counter = r_reload;
            end else begin
                n_counter = r_counter - 8'd1;
            end
            if ((n_counter == 8'd0) && r_enabled) begin
                n_delay = bsm_pkg::IRQ_DELAY_CYCLES;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_counter    <= '0;
            r_reload     <= bsm_pkg::RELOAD_RST;
            r_reload_req <= 1'b0;
            r_enabled    <= 1'b0;
            r_cycle_mode <= 1'b0;
            r_prescaler  <= bsm_pkg::PRESCALE_DIV;
            r_delay      <= '0;
            r_prev_a12   <= 1'b0;
            r_flag       <= 1'b0;
        end else if (i_evt.valid) begin
            r_counter    <= n_counter;
            r_reload     <= n_reload;
            r_reload_req <= n_reload_req;
            r_enabled    <= n_enabled;
            r_cycle_mode <= n_cycle_mode;
            r_prescaler  <= n_prescaler;
            r_delay      <= n_delay;
            r_prev_a12   <= n_prev_a12;
            r_flag       <= n_flag;
        end
    end

    assign o_irq = n_flag;

endmodule

`default_nettype wire

// ===== rtl/bank_switch_mapper_with_counter_irq.sv =====
// throughput: one item per cycle while the result side is not stalled;
// input register, one step of decode and state update, then the result
// register (set by that single update step)
// reset: synchronous active low; clears both pipeline stages, bank and irq
// state to their power-on values and the masks to their defaults
`timescale 1ns / 1ps
`default_nettype none

module bank_switch_mapper_with_counter_irq (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire logic [1:0]                i_operation,
    input  wire logic [15:0]               i_address,
    input  wire logic [7:0]                i_write_data,
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output logic [bsm_pkg::PRG_W-1:0]      o_mapped_address,
    output logic                           o_irq_line,
    output logic                           o_mirror_horizontal,
    input  wire logic                      i_cfg_we,
    input  wire logic                      i_cfg_index,
    input  wire logic [bsm_pkg::CFG_W-1:0] i_cfg_data
);

    logic                      r_in_valid;
    bsm_pkg::t_op              r_in_op;
    logic [15:0]               r_in_addr;
    logic [7:0]                r_in_data;
    logic                      r_out_valid;
    logic [bsm_pkg::PRG_W-1:0] r_out_mapped;
    logic                      r_out_irq;
    logic                      r_out_mirror;

    logic                      advance;
    bsm_pkg::t_wsel            wsel;
    bsm_pkg::t_evt             evt;
    bsm_pkg::t_cfg             cfg;
    logic [bsm_pkg::PRG_W-1:0] step_mapped;
    logic                      step_irq;
    logic                      step_mirror;

    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_op   <= bsm_pkg::t_op'(i_operation);
            r_in_addr <= i_address;
            r_in_data <= i_write_data;
        end
    end

    // register write decode
    always_comb begin
        unique case (r_in_addr & bsm_pkg::WR_DECODE_MASK)
            bsm_pkg::ADDR_BANK_SEL:  wsel = bsm_pkg::WR_BANK_SEL;
            bsm_pkg::ADDR_BANK_DATA: wsel = bsm_pkg::WR_BANK_DATA;
            bsm_pkg::ADDR_MIRROR:    wsel = bsm_pkg::WR_MIRROR;
            bsm_pkg::ADDR_RELOAD:    wsel = bsm_pkg::WR_RELOAD;
            bsm_pkg::ADDR_IRQ_RESET: wsel = bsm_pkg::WR_IRQ_RESET;
            bsm_pkg::ADDR_IRQ_DIS:   wsel = bsm_pkg::WR_IRQ_DIS;
            bsm_pkg::ADDR_IRQ_EN:    wsel = bsm_pkg::WR_IRQ_EN;
            default:                 wsel = bsm_pkg::WR_NONE;
        endcase
    end

    always_comb begin
        evt.valid = advance;
        evt.wsel  = (advance && (r_in_op == bsm_pkg::OP_REG_WRITE)) ? wsel : bsm_pkg::WR_NONE;
        evt.prg   = advance && (r_in_op == bsm_pkg::OP_PRG_XLATE);
        evt.chr   = advance && (r_in_op == bsm_pkg::OP_CHR_ACCESS);
        evt.tick  = advance && (r_in_op == bsm_pkg::OP_CPU_TICK);
        evt.addr  = r_in_addr;
        evt.data  = r_in_data;
    end

    assign cfg.we    = i_cfg_we;
    assign cfg.index = bsm_pkg::t_cfg_idx'(i_cfg_index);
    assign cfg.data  = i_cfg_data;

    bsm_banks u_banks (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_evt    (evt),
        .i_cfg    (cfg),
        .o_mapped (step_mapped),
        .o_mirror (step_mirror)
    );

    bsm_irq u_irq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_evt   (evt),
        .o_irq   (step_irq)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_mapped <= step_mapped;
            r_out_irq    <= step_irq;
            r_out_mirror <= step_mirror;
        end
    end

    assign o_valid             = r_out_valid;
    assign o_mapped_address    = r_out_mapped;
    assign o_irq_line          = r_out_irq;
    assign o_mirror_horizontal = r_out_mirror;

endmodule

`default_nettype wire

// ===== rtl/bsm_checker.sv =====
// bsm_checker: port level checks for the mapper top level, bound below
// depends on bsm_pkg and bank_switch_mapper_with_counter_irq
`timescale 1ns / 1ps
`default_nettype none

module bsm_checker (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    input  wire logic                      o_ready,
    input  wire logic                      o_valid,
    input  wire logic                      i_ready,
    input  wire logic [bsm_pkg::PRG_W-1:0] o_mapped_address,
    input  wire logic                      o_irq_line,
    input  wire logic                      o_mirror_horizontal
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_mapped_address)
            && $stable(o_irq_line) && $stable(o_mirror_horizontal))
        else $error("result beat changed while stalled");

    // empty output stage never blocks input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input blocked with empty output stage");

    // every taken beat shows up as a result
    a_beat_reaches_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |-> ##2 o_valid)
        else $error("accepted beat did not reach output");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

endmodule

bind bank_switch_mapper_with_counter_irq bsm_checker u_bsm_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_valid             (i_valid),
    .o_ready             (o_ready),
    .o_valid             (o_valid),
    .i_ready             (i_ready),
    .o_mapped_address    (o_mapped_address),
    .o_irq_line          (o_irq_line),
    .o_mirror_horizontal (o_mirror_horizontal)
);

`default_nettype wire
